// File: rtl/pmf_pkg.sv
// Shared types, constants and helper functions of the pixellate mosaic frame block.
// No dependencies; every other file of the block imports this package.
package pmf_pkg;

   // Fixed field widths of the request, response and register ports.
   localparam int COORD_W  = 8;
   localparam int PIXEL_W  = 32;
   localparam int BSIZE_W  = 7;
   localparam int DIM_W    = 9;
   localparam int CSR_W    = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CTR_W    = 9;
   localparam int REQ_DATA_W = 2 * COORD_W + PIXEL_W;

   // Largest frame in use; larger register values saturate to it.
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   // Largest mosaic block side; larger register values saturate to it.
   localparam int MAX_BLOCK = 64;

   // Remainder iterations take one dividend bit per cycle.
   localparam int STEP_W = $clog2(COORD_W);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_SIZE   = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   // Request kinds carried in tuser.
   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_READ  = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CENTER,
      ST_READ,
      ST_RESP
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic center_load;
      logic mem_write;
      logic mem_read;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic req_read;
   } status_type;

   // One restoring step of the remainder: shift in the next dividend bit and
   // subtract the divisor when it fits.
   function automatic logic [BSIZE_W-1:0] rem_step(input logic [BSIZE_W-1:0] rem,
                                                   input logic               dbit,
                                                   input logic [BSIZE_W-1:0] size);
      logic [BSIZE_W:0] trial;
      trial = {rem, dbit};
      if (trial >= {1'b0, size}) begin
         trial = trial - {1'b0, size};
      end
      return trial[BSIZE_W-1:0];
   endfunction

endpackage

// File: rtl/pmf_ctrl.sv
// Sequencing state machine of the pixellate mosaic frame block.
// Depends on pmf_pkg; drives the commands of pmf_datapath.
module pmf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  pmf_pkg::status_type sts,
   output pmf_pkg::cmd_type    cmd
);
   import pmf_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COORD_W - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      accept     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept) begin
               if (sts.req_read) begin
                  cmd.load = 1'b1;
                  step_in  = '0;
                  state_in = ST_DIV;
               end else begin
                  cmd.mem_write = 1'b1;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_CENTER;
            end
         end
         ST_CENTER: begin
            cmd.center_load = 1'b1;
            state_in        = ST_READ;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/pmf_datapath.sv
// Datapath of the pixellate mosaic frame block: registers, remainder unit,
// center computation and frame memory. Depends on pmf_pkg; steered by pmf_ctrl.
module pmf_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_type,
   input  logic [pmf_pkg::COORD_W-1:0]       col_x,
   input  logic [pmf_pkg::COORD_W-1:0]       row_y,
   input  logic [pmf_pkg::PIXEL_W-1:0]       write_pixel,
   input  logic                              csr_we,
   input  logic [pmf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pmf_pkg::CSR_W-1:0]         csr_wdata,
   input  pmf_pkg::cmd_type                  cmd,
   output pmf_pkg::status_type               sts,
   output logic [pmf_pkg::PIXEL_W-1:0]       read_pixel
);
   import pmf_pkg::*;

   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int ADDR_W = XW + YW;
   localparam int DEPTH  = 1 << ADDR_W;

   // Configuration registers.
   logic [BSIZE_W-1:0] bsize_ff, bsize_in;
   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;

   // Effective (saturated) configuration.
   logic [BSIZE_W-1:0] size_eff;
   logic [DIM_W-1:0]   width_eff, height_eff;
   logic [DIM_W-1:0]   width_m1, height_m1;

   logic [COORD_W-1:0] x_clamp, y_clamp;
   logic               wr_in_range;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;

   // Remainder unit state.
   logic [COORD_W-1:0] x_pos_ff, x_pos_in, y_pos_ff, y_pos_in;
   logic [COORD_W-1:0] x_div_ff, x_div_in, y_div_ff, y_div_in;
   logic [BSIZE_W-1:0] x_rem_ff, x_rem_in, y_rem_ff, y_rem_in;

   // Block centers.
   logic [BSIZE_W-1:0] size_m1;
   logic [BSIZE_W-2:0] half;
   logic [CTR_W-1:0]   x_ctr_raw, y_ctr_raw;
   logic [CTR_W-1:0]   x_ctr_ff, x_ctr_in, y_ctr_ff, y_ctr_in;

   logic [PIXEL_W-1:0] frame_ff [DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   // Configuration writes.
   always_comb begin
      bsize_in  = bsize_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_SIZE:   bsize_in  = csr_wdata[BSIZE_W-1:0];
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff  <= BSIZE_W'(1);
         width_ff  <= DIM_W'(MAX_WIDTH);
         height_ff <= DIM_W'(MAX_HEIGHT);
      end else begin
         bsize_ff  <= bsize_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      if (bsize_ff == '0) begin
         size_eff = BSIZE_W'(1);
      end else if (32'(bsize_ff) > MAX_BLOCK) begin
         size_eff = BSIZE_W'(MAX_BLOCK);
      end else begin
         size_eff = bsize_ff;
      end

      if (width_ff == '0) begin
         width_eff = DIM_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         width_eff = DIM_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end

      if (height_ff == '0) begin
         height_eff = DIM_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         height_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         height_eff = height_ff;
      end
   end

   assign width_m1  = width_eff - 1'b1;
   assign height_m1 = height_eff - 1'b1;

   // Reads clamp to the last column and row in use; writes outside are dropped.
   assign x_clamp = (DIM_W'(col_x) > width_m1)  ? width_m1[COORD_W-1:0]  : col_x;
   assign y_clamp = (DIM_W'(row_y) > height_m1) ? height_m1[COORD_W-1:0] : row_y;

   assign wr_in_range = (DIM_W'(col_x) < width_eff) && (DIM_W'(row_y) < height_eff);
   assign wr_addr     = {YW'(row_y), XW'(col_x)};

   assign sts.req_read = (req_type == REQ_READ);

   // Remainder of each coordinate by the block size, one bit per cycle.
   always_comb begin
      x_pos_in = x_pos_ff;
      y_pos_in = y_pos_ff;
      x_div_in = x_div_ff;
      y_div_in = y_div_ff;
      x_rem_in = x_rem_ff;
      y_rem_in = y_rem_ff;
      if (cmd.load) begin
         x_pos_in = x_clamp;
         y_pos_in = y_clamp;
         x_div_in = x_clamp;
         y_div_in = y_clamp;
         x_rem_in = '0;
         y_rem_in = '0;
      end else if (cmd.div_step) begin
         x_div_in = {x_div_ff[COORD_W-2:0], 1'b0};
         y_div_in = {y_div_ff[COORD_W-2:0], 1'b0};
         x_rem_in = rem_step(x_rem_ff, x_div_ff[COORD_W-1], size_eff);
         y_rem_in = rem_step(y_rem_ff, y_div_ff[COORD_W-1], size_eff);
      end
   end

   // Center = block start + (size-1)/2, clamped to the last column or row.
   assign size_m1   = size_eff - 1'b1;
   assign half      = size_m1[BSIZE_W-1:1];
   assign x_ctr_raw = CTR_W'(x_pos_ff - COORD_W'(x_rem_ff)) + CTR_W'(half);
   assign y_ctr_raw = CTR_W'(y_pos_ff - COORD_W'(y_rem_ff)) + CTR_W'(half);

   always_comb begin
      x_ctr_in = x_ctr_ff;
      y_ctr_in = y_ctr_ff;
      if (cmd.center_load) begin
         x_ctr_in = (x_ctr_raw > width_m1)  ? width_m1  : x_ctr_raw;
         y_ctr_in = (y_ctr_raw > height_m1) ? height_m1 : y_ctr_raw;
      end
   end

   always_ff @(posedge clock) begin
      x_pos_ff <= x_pos_in;
      y_pos_ff <= y_pos_in;
      x_div_ff <= x_div_in;
      y_div_ff <= y_div_in;
      x_rem_ff <= x_rem_in;
      y_rem_ff <= y_rem_in;
      x_ctr_ff <= x_ctr_in;
      y_ctr_ff <= y_ctr_in;
   end

   assign rd_addr = {YW'(y_ctr_ff), XW'(x_ctr_ff)};

   // Frame memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.mem_write && wr_in_range) begin
         frame_ff[wr_addr] <= write_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_data_ff <= frame_ff[rd_addr];
      end
   end

   assign read_pixel = rd_data_ff;

endmodule

// File: rtl/pixellate_mosaic_frame_core.sv
// Pixellate mosaic frame block: holds a source frame and returns the block-center
// sample of the mosaic for each read. Depends on pmf_pkg, pmf_ctrl and pmf_datapath.
// Writes complete in the idle state. A read runs the bit-serial remainder unit, then
// the center clamp, the frame read and the response; the next request transfer is
// taken only once the response transfer has completed.
// Synchronous active-high reset sets block size 1, 256 x 256; the frame is not cleared.
module pixellate_mosaic_frame_core (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pmf_pkg::REQ_DATA_W-1:0]    req_tdata,  // col_x, row_y, write_pixel
   input  logic                              req_tuser,  // req_type
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pmf_pkg::PIXEL_W-1:0]       rsp_tdata,  // read_pixel
   // Configuration write port.
   input  logic                              csr_we,
   input  logic [pmf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pmf_pkg::CSR_W-1:0]         csr_wdata
);
   import pmf_pkg::*;

   cmd_type            cmd;
   status_type         sts;
   logic [COORD_W-1:0] col_x;
   logic [COORD_W-1:0] row_y;
   logic [PIXEL_W-1:0] write_pixel;

   // Unpack the request transfer: column in the lowest byte, then row, then pixel.
   assign col_x       = req_tdata[COORD_W-1:0];
   assign row_y       = req_tdata[2*COORD_W-1:COORD_W];
   assign write_pixel = req_tdata[REQ_DATA_W-1:2*COORD_W];

   // The controller accepts one request at a time; a read holds the request
   // side until its response transfer completes.
   pmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath owns the configuration registers, the remainder unit and the
   // frame memory; its registered read data is the response payload.
   pmf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_type    (req_tuser),
      .col_x       (col_x),
      .row_y       (row_y),
      .write_pixel (write_pixel),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts),
      .read_pixel  (rsp_tdata)
   );

endmodule
